/* rtl/skt_pkg.sv */
package skt_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int PAY_W    = 32;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;

  localparam logic [2:0] STAT_INSERTED = 3'd0;
  localparam logic [2:0] STAT_REPLACED = 3'd1;
  localparam logic [2:0] STAT_REMOVED  = 3'd2;
  localparam logic [2:0] STAT_FOUND    = 3'd3;
  localparam logic [2:0] STAT_MISSING  = 3'd4;
  localparam logic [2:0] STAT_FULL     = 3'd5;

  localparam logic REG_SIGNED_ORDER = 1'b0;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [PAY_W-1:0]    payload;
  } entry_t;

  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

endpackage

/* rtl/skt_mem.sv */
module skt_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [skt_pkg::IDX_W-1:0]     wr_addr,
  input  skt_pkg::entry_t               wr_data,
  input  logic [skt_pkg::IDX_W-1:0]     rd_addr,
  output skt_pkg::entry_t               rd_data
);

  skt_pkg::entry_t mem [skt_pkg::DEPTH];
  skt_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/skt_cmp.sv */
module skt_cmp (
  input  logic                          signed_order,
  input  logic [skt_pkg::KEY_BITS-1:0]  want,
  input  logic [skt_pkg::KEY_BITS-1:0]  have,
  output skt_pkg::cmp_res_t             res
);

  logic [skt_pkg::KEY_BITS-1:0] flip;
  logic [skt_pkg::KEY_BITS-1:0] want_o;
  logic [skt_pkg::KEY_BITS-1:0] have_o;

  // flipping the sign bit maps two's complement order onto unsigned order
  assign flip   = {signed_order, {(skt_pkg::KEY_BITS-1){1'b0}}};
  assign want_o = want ^ flip;
  assign have_o = have ^ flip;

  assign res.gt = want_o > have_o;
  assign res.lt = want_o < have_o;

endmodule

/* rtl/sorted_key_table.sv */
// Sorted key table: up to 16 key/payload entries held in ascending key order.
// Requests: drive in_func, in_key and in_payload and raise start; the request
// is taken at a clock edge where start is high and busy is low. busy stays
// high until the result has been presented.
// Results: one per request, on the out_ ports for exactly one cycle while
// out_valid is high. The receiver cannot stall; the result must be taken then.
// Operation: a binary search of up to five probes, each a read and a
// compare, on the entry RAM and one shared key comparator, then up to 15
// shift steps (read, write) for insert or remove, one more write for
// insert. An unused operation code goes straight to its result without a
// search. Only one request is in flight at a time.
// Configuration: APB register 0 at byte address 0, bit 0 selects signed key
// order. Write it only while busy is low.
// Reset (rst_n low, synchronous): the table is emptied and unsigned order
// selected; entry storage is not cleared and needs no clearing pass.
module sorted_key_table (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,

  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [31:0]                   in_key,
  input  logic [31:0]                   in_payload,

  output logic                          out_valid,
  output logic [2:0]                    out_status,
  output logic [4:0]                    out_position,
  output logic [4:0]                    out_entry_count,
  output logic [31:0]                   out_result_payload,
  output logic                          out_displaced
);

  localparam int CW = skt_pkg::CNT_W;
  localparam int IW = skt_pkg::IDX_W;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SRCH   = 10'b0000000010,
    S_SCMP   = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_SHU_RD = 10'b0000010000,
    S_SHU_WR = 10'b0000100000,
    S_SHD_RD = 10'b0001000000,
    S_SHD_WR = 10'b0010000000,
    S_PUT    = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         signed_order_r, signed_order_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                j_r, j_nxt;
  logic [IW-1:0]                mid_r, mid_nxt;
  logic                         hit_r, hit_nxt;
  logic [1:0]                   func_r, func_nxt;
  logic [skt_pkg::KEY_BITS-1:0] key_r, key_nxt;
  logic [31:0]                  pay_r, pay_nxt;
  logic [2:0]                   status_r, status_nxt;
  logic [CW-1:0]                pos_r, pos_nxt;
  logic [31:0]                  res_r, res_nxt;
  logic                         disp_r, disp_nxt;

  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  skt_pkg::entry_t              wr_data;
  logic [IW-1:0]                rd_addr;
  skt_pkg::entry_t              rd_data;
  skt_pkg::cmp_res_t            cmp;
  logic [CW-1:0]                mid_full;
  logic                         accept;
  logic                         cfg_wr;

  skt_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  skt_cmp u_cmp (
    .signed_order (signed_order_r),
    .want         (key_r),
    .have         (rd_data.key),
    .res          (cmp)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == skt_pkg::REG_SIGNED_ORDER) ? {31'd0, signed_order_r} : 32'd0;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign mid_full  = lo_r + ((hi_r - lo_r) >> 1);

  assign out_valid          = (state_r == S_RESP);
  assign out_status         = status_r;
  assign out_position       = pos_r;
  assign out_entry_count    = fill_r;
  assign out_result_payload = res_r;
  assign out_displaced      = disp_r;

  always_comb begin
    state_nxt        = state_r;
    signed_order_nxt = signed_order_r;
    fill_nxt         = fill_r;
    lo_nxt           = lo_r;
    hi_nxt           = hi_r;
    j_nxt            = j_r;
    mid_nxt          = mid_r;
    hit_nxt          = hit_r;
    func_nxt         = func_r;
    key_nxt          = key_r;
    pay_nxt          = pay_r;
    status_nxt       = status_r;
    pos_nxt          = pos_r;
    res_nxt          = res_r;
    disp_nxt         = disp_r;
    wr_en            = 1'b0;
    wr_addr          = pos_r[IW-1:0];
    wr_data          = '{key: key_r, payload: pay_r};
    rd_addr          = mid_r;

    if (cfg_wr && paddr[2] == skt_pkg::REG_SIGNED_ORDER) begin
      signed_order_nxt = pwdata[0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt   = in_func;
          key_nxt    = in_key[skt_pkg::KEY_BITS-1:0];
          pay_nxt    = in_payload;
          lo_nxt     = '0;
          hi_nxt     = fill_r;
          hit_nxt    = 1'b0;
          status_nxt = skt_pkg::STAT_MISSING;
          pos_nxt    = '0;
          res_nxt    = '0;
          disp_nxt   = 1'b0;
          if (in_func == skt_pkg::FN_INSERT || in_func == skt_pkg::FN_REMOVE ||
              in_func == skt_pkg::FN_LOOKUP) begin
            state_nxt = S_SRCH;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_full[IW-1:0];
          rd_addr   = mid_full[IW-1:0];
          state_nxt = S_SCMP;
        end else begin
          pos_nxt   = lo_r;
          state_nxt = S_DECIDE;
        end
      end
      S_SCMP: begin
        if (cmp.gt) begin
          lo_nxt    = {1'b0, mid_r} + CW'(1);
          state_nxt = S_SRCH;
        end else if (cmp.lt) begin
          hi_nxt    = {1'b0, mid_r};
          state_nxt = S_SRCH;
        end else begin
          hit_nxt   = 1'b1;
          pos_nxt   = {1'b0, mid_r};
          res_nxt   = rd_data.payload;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        if (func_r == skt_pkg::FN_INSERT) begin
          if (hit_r) begin
            wr_en      = 1'b1;
            status_nxt = skt_pkg::STAT_REPLACED;
            disp_nxt   = 1'b1;
          end else if (fill_r == CW'(skt_pkg::DEPTH)) begin
            status_nxt = skt_pkg::STAT_FULL;
          end else if (fill_r > pos_r) begin
            j_nxt     = fill_r;
            state_nxt = S_SHU_RD;
          end else begin
            state_nxt = S_PUT;
          end
        end else if (func_r == skt_pkg::FN_REMOVE) begin
          if (hit_r) begin
            status_nxt = skt_pkg::STAT_REMOVED;
            disp_nxt   = 1'b1;
            j_nxt      = pos_r;
            if (pos_r + CW'(1) < fill_r) begin
              state_nxt = S_SHD_RD;
            end else begin
              fill_nxt = fill_r - CW'(1);
            end
          end
        end else begin
          if (hit_r) begin
            status_nxt = skt_pkg::STAT_FOUND;
          end
        end
      end
      S_SHU_RD: begin
        rd_addr   = IW'(j_r - CW'(1));
        state_nxt = S_SHU_WR;
      end
      S_SHU_WR: begin
        wr_en   = 1'b1;
        wr_addr = j_r[IW-1:0];
        wr_data = rd_data;
        j_nxt   = j_r - CW'(1);
        if (j_r - CW'(1) > pos_r) begin
          state_nxt = S_SHU_RD;
        end else begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        wr_en      = 1'b1;
        fill_nxt   = fill_r + CW'(1);
        status_nxt = skt_pkg::STAT_INSERTED;
        state_nxt  = S_RESP;
      end
      S_SHD_RD: begin
        rd_addr   = IW'(j_r + CW'(1));
        state_nxt = S_SHD_WR;
      end
      S_SHD_WR: begin
        wr_en   = 1'b1;
        wr_addr = j_r[IW-1:0];
        wr_data = rd_data;
        j_nxt   = j_r + CW'(1);
        if (j_r + CW'(2) < fill_r) begin
          state_nxt = S_SHD_RD;
        end else begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      signed_order_r <= 1'b0;
      fill_r         <= '0;
    end else begin
      state_r        <= state_nxt;
      signed_order_r <= signed_order_nxt;
      fill_r         <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    j_r      <= j_nxt;
    mid_r    <= mid_nxt;
    hit_r    <= hit_nxt;
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    status_r <= status_nxt;
    pos_r    <= pos_nxt;
    res_r    <= res_nxt;
    disp_r   <= disp_nxt;
  end

endmodule

/* tb/tb_sorted_key_table.sv */
`timescale 1ns / 100ps

module tb_sorted_key_table;

  localparam logic [1:0] FN_UNUSED         = 2'd3;
  localparam logic [2:0] ADDR_SIGNED_ORDER = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
  localparam int         KEY_POOL          = 24;
  localparam int         IDLE_LIMIT        = 4000;
  localparam int         DRAIN_CYCLES      = 60;

  typedef struct packed {
    logic [1:0]                   func;
    logic [skt_pkg::KEY_BITS-1:0] key;
    logic [skt_pkg::PAY_W-1:0]    payload;
  } request_t;

  typedef struct packed {
    logic [2:0]                status;
    logic [4:0]                position;
    logic [4:0]                entry_count;
    logic [skt_pkg::PAY_W-1:0] result_payload;
    logic                      displaced;
  } table_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_func = skt_pkg::FN_LOOKUP;
  logic [31:0]       in_key = '0;
  logic [31:0]       in_payload = '0;
  logic              out_valid;
  logic [2:0]        out_status;
  logic [4:0]        out_position;
  logic [4:0]        out_entry_count;
  logic [31:0]       out_result_payload;
  logic              out_displaced;

  request_t          pending_requests[$];
  table_result_t     expected_results[$];
  request_t          current_request;

  logic [skt_pkg::KEY_BITS-1:0] model_keys[skt_pkg::DEPTH];
  logic [skt_pkg::PAY_W-1:0]    model_payloads[skt_pkg::DEPTH];
  int                           model_fill = 0;
  logic                         order_signed = 1'b0;

  logic [skt_pkg::KEY_BITS-1:0] key_pool[KEY_POOL];
  int                  burst_left = 0;
  int                  gap_left = 0;
  int                  idle_cycles = 0;
  int                  mismatches = 0;

  sorted_key_table dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_position       (out_position),
    .out_entry_count    (out_entry_count),
    .out_result_payload (out_result_payload),
    .out_displaced      (out_displaced)
  );

  always #5 clk = ~clk;

  function automatic logic [skt_pkg::KEY_BITS-1:0] ordered_key(
    logic [skt_pkg::KEY_BITS-1:0] k);
    logic [skt_pkg::KEY_BITS-1:0] flip;
    flip = '0;
    flip[skt_pkg::KEY_BITS-1] = order_signed;
    return k ^ flip;
  endfunction

  function automatic table_result_t apply_request(request_t rq);
    table_result_t                res;
    int                           lo;
    int                           hi;
    int                           mid;
    int                           slot;
    logic                         hit;
    logic [skt_pkg::KEY_BITS-1:0] want;
    logic [skt_pkg::KEY_BITS-1:0] have;
    res = '0;
    res.status = skt_pkg::STAT_MISSING;
    slot = 0;
    hit = 1'b0;
    if (rq.func != FN_UNUSED) begin
      lo = 0;
      hi = model_fill;
      want = ordered_key(rq.key);
      while (lo < hi && !hit) begin
        mid = lo + (hi - lo) / 2;
        have = ordered_key(model_keys[mid]);
        if (want > have) begin
          lo = mid + 1;
        end else if (want < have) begin
          hi = mid;
        end else begin
          hit = 1'b1;
          lo = mid;
        end
      end
      slot = lo;
    end
    case (rq.func)
      skt_pkg::FN_INSERT: begin
        if (hit) begin
          res.result_payload = model_payloads[slot];
          model_keys[slot] = rq.key;
          model_payloads[slot] = rq.payload;
          res.status = skt_pkg::STAT_REPLACED;
          res.displaced = 1'b1;
        end else if (model_fill >= skt_pkg::DEPTH) begin
          res.status = skt_pkg::STAT_FULL;
        end else begin
          for (int i = model_fill; i > slot; i--) begin
            model_keys[i] = model_keys[i-1];
            model_payloads[i] = model_payloads[i-1];
          end
          model_keys[slot] = rq.key;
          model_payloads[slot] = rq.payload;
          model_fill++;
          res.status = skt_pkg::STAT_INSERTED;
        end
      end
      skt_pkg::FN_REMOVE: begin
        if (hit) begin
          res.result_payload = model_payloads[slot];
          for (int i = slot; i + 1 < model_fill; i++) begin
            model_keys[i] = model_keys[i+1];
            model_payloads[i] = model_payloads[i+1];
          end
          model_fill--;
          res.status = skt_pkg::STAT_REMOVED;
          res.displaced = 1'b1;
        end
      end
      skt_pkg::FN_LOOKUP: begin
        if (hit) begin
          res.result_payload = model_payloads[slot];
          res.status = skt_pkg::STAT_FOUND;
        end
      end
      default: ;
    endcase
    res.position = slot[4:0];
    res.entry_count = model_fill[4:0];
    return res;
  endfunction

  // request driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(apply_request(current_request));
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          current_request = pending_requests.pop_front();
          in_func <= current_request.func;
          in_key <= current_request.key;
          in_payload <= current_request.payload;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(30, 1);
            gap_left <= ($urandom_range(9) < 3) ? 0 : $urandom_range(25, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("result: expected none, actual status %0d", out_status);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", 32'(exp_r.status), 32'(out_status));
        check_field("position", 32'(exp_r.position), 32'(out_position));
        check_field("entry_count", 32'(exp_r.entry_count), 32'(out_entry_count));
        check_field("result_payload", exp_r.result_payload, out_result_payload);
        check_field("displaced", 32'(exp_r.displaced), 32'(out_displaced));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_request(logic [1:0] func, logic [31:0] key, logic [31:0] payload);
    request_t rq;
    rq.func = func;
    rq.key = key;
    rq.payload = payload;
    pending_requests.push_back(rq);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || start || busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_SIGNED_ORDER) order_signed = data[0];
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r < 6) return key_pool[$urandom_range(KEY_POOL - 1)];
    if (r == 6) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        3: return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_random_phase(int count);
    int          chunk;
    int          insert_pct;
    int          r;
    logic [1:0]  func;
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
    while (count > 0) begin
      chunk = $urandom_range(75, 25);
      case ($urandom_range(2))
        0: insert_pct = 20;
        1: insert_pct = 50;
        default: insert_pct = 85;
      endcase
      for (int i = 0; i < chunk && count > 0; i++) begin
        r = $urandom_range(99);
        if (r == 99) func = FN_UNUSED;
        else if (r < insert_pct) func = skt_pkg::FN_INSERT;
        else if (r[0]) func = skt_pkg::FN_REMOVE;
        else func = skt_pkg::FN_LOOKUP;
        push_request(func, pick_key(), $urandom);
        count--;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(ADDR_SIGNED_ORDER, 32'd0);

    // empty table, unused op, extremes, replace, misses, fill to full
    push_request(skt_pkg::FN_LOOKUP, 32'h0000_0000, $urandom);
    push_request(skt_pkg::FN_REMOVE, 32'h0000_0005, $urandom);
    push_request(FN_UNUSED, $urandom, $urandom);
    push_request(skt_pkg::FN_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(skt_pkg::FN_INSERT, 32'h0000_0000, 32'h0000_0000);
    push_request(skt_pkg::FN_INSERT, 32'h8000_0000, 32'hA5A5_A5A5);
    push_request(skt_pkg::FN_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
    push_request(skt_pkg::FN_LOOKUP, 32'hFFFF_FFFF, $urandom);
    push_request(skt_pkg::FN_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    push_request(skt_pkg::FN_REMOVE, 32'h8000_0000, $urandom);
    push_request(skt_pkg::FN_REMOVE, 32'h0001_2345, $urandom);
    for (int i = 1; i <= 13; i++) begin
      push_request(skt_pkg::FN_INSERT, i * 32'h1111_1111, $urandom);
    end
    push_request(skt_pkg::FN_INSERT, 32'h0000_0040, $urandom);
    push_request(FN_UNUSED, $urandom, $urandom);
    wait_drained();

    cfg_write(ADDR_SIGNED_ORDER, 32'd1);
    queue_random_phase(310);
    wait_drained();

    cfg_write(ADDR_UNMAPPED, 32'hFFFF_FFFE);
    cfg_write(ADDR_SIGNED_ORDER, 32'd0);
    queue_random_phase(310);
    wait_drained();

    cfg_write(ADDR_SIGNED_ORDER, 32'hFFFF_FFFF);
    queue_random_phase(310);
    wait_drained();

    cfg_write(ADDR_SIGNED_ORDER, 32'hFFFF_FFFE);
    queue_random_phase(310);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sorted_key_table.f */
rtl/skt_pkg.sv
rtl/skt_mem.sv
rtl/skt_cmp.sv
rtl/sorted_key_table.sv
tb/tb_sorted_key_table.sv
